// File: sv/shift_array_insert_delete_unit_assert.svh
// assertion macros shared by the shift array insert/delete unit
// expects clk and rst in the scope of each use
`ifndef SHIFT_ARRAY_INSERT_DELETE_UNIT_ASSERT_SVH
`define SHIFT_ARRAY_INSERT_DELETE_UNIT_ASSERT_SVH

// same-cycle implication
`define SAI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sai_pkg.sv
// types and codes for the shift array insert/delete unit
// no dependencies
package sai_pkg;

  localparam int MODE_W   = 2;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;
  localparam int IDX_W    = 8;
  localparam int CMD_W    = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELVAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CMD_W-1:0] CMD_HOLD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic [IDX_W-1:0]         tail;
    logic                     keep;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill_count;
    logic signed [DATA_W-1:0] read_data;
    logic [FILL_W-1:0]        removed_count;
  } result_t;

endpackage

// File: sv/sai_if.sv
// request and response channel interfaces of the shift array unit
// depends on sai_pkg
interface sai_req_if;
  import sai_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, mode, value, position, input ready);
  modport sink (input valid, mode, value, position, output ready);
endinterface

interface sai_rsp_if;
  import sai_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [FILL_W-1:0]        fill_count;
  logic signed [DATA_W-1:0] read_data;
  logic [FILL_W-1:0]        removed_count;

  modport source (output valid, status, fill_count, read_data, removed_count, input ready);
  modport sink (input valid, status, fill_count, read_data, removed_count, output ready);
endinterface

// File: sv/sai_cell.sv
// one entry of the shift chain: holds a word and takes a neighbor's, the new value or the head word on command
// depends on sai_pkg
module sai_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  sai_pkg::cell_ctl_t               ctl,
  input  logic signed [sai_pkg::DATA_W-1:0] left,
  input  logic signed [sai_pkg::DATA_W-1:0] right,
  input  logic signed [sai_pkg::DATA_W-1:0] head,
  output logic signed [sai_pkg::DATA_W-1:0] q
);
  import sai_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [IDX_W-1:0]         pos_x;
  logic signed [DATA_W-1:0] q_next;

  assign pos_x = IDX_W'(ctl.pos);

  always_comb begin
    q_next = q;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (MY_IDX == pos_x) begin
          q_next = ctl.value;
        end else if (MY_IDX > pos_x) begin
          q_next = left;
        end
      end
      CMD_DELETE: begin
        if (MY_IDX >= pos_x) begin
          q_next = right;
        end
      end
      CMD_SWEEP: begin
        // kept head word re-enters at the tail of the live queue
        if (MY_IDX == ctl.tail && ctl.keep) begin
          q_next = head;
        end else begin
          q_next = right;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// File: sv/sai_ctrl.sv
// sequencer: fill count, sweep counters, result staging and output register
// depends on sai_pkg, sai_if, shift_array_insert_delete_unit_assert.svh
`include "shift_array_insert_delete_unit_assert.svh"

module sai_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  sai_req_if.sink                          req,
  sai_rsp_if.source                        rsp,
  input  logic signed [sai_pkg::DATA_W-1:0] head,
  output sai_pkg::cell_ctl_t               ctl
);
  import sai_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic STATE_IDLE  = 1'b0;
  localparam logic STATE_SWEEP = 1'b1;

  logic                     state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            len, len_next;
  logic [CW-1:0]            step, step_next;
  logic [MODE_W-1:0]        mode_r;
  logic signed [DATA_W-1:0] value_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] rdata_r, rdata_next;
  logic                     pend_valid;
  result_t                  pend, pend_next;
  logic                     pend_set;
  logic                     out_valid;
  result_t                  out_q;
  logic                     out_load;

  logic          accept;
  logic [XW-1:0] pos_x, cnt_x;
  logic          head_keep;
  logic          read_hit;
  logic          last_step;
  logic [CW-1:0] len_after;

  assign req.ready = (state == STATE_IDLE) && !pend_valid;
  assign accept    = req.valid && req.ready;
  assign pos_x     = XW'(req.position);
  assign cnt_x     = XW'(count);
  assign head_keep = (mode_r == MODE_READ) || (head != value_r);
  assign read_hit  = (mode_r == MODE_READ) && (XW'(step) == XW'(pos_r));
  assign last_step = (step == count - CW'(1));
  assign len_after = head_keep ? len : len - CW'(1);

  always_comb begin
    state_next = state;
    count_next = count;
    len_next   = len;
    step_next  = step;
    rdata_next = rdata_r;
    pend_set   = 1'b0;
    pend_next  = '0;
    ctl.cmd    = CMD_HOLD;
    ctl.pos    = req.position;
    ctl.tail   = IDX_W'(len - CW'(1));
    ctl.keep   = head_keep;
    ctl.value  = req.value;
    if (state == STATE_IDLE) begin
      if (accept) begin
        case (req.mode)
          MODE_INSERT: begin
            pend_set = 1'b1;
            if (count >= CAP_C) begin
              pend_next.status = ST_FULL;
            end else if (pos_x > cnt_x) begin
              pend_next.status = ST_RANGE;
            end else begin
              ctl.cmd    = CMD_INSERT;
              count_next = count + CW'(1);
            end
          end
          MODE_DELETE: begin
            pend_set = 1'b1;
            if (pos_x >= cnt_x) begin
              pend_next.status = ST_RANGE;
            end else begin
              ctl.cmd                 = CMD_DELETE;
              count_next              = count - CW'(1);
              pend_next.removed_count = FILL_W'(1);
            end
          end
          MODE_DELVAL: begin
            if (count == '0) begin
              pend_set = 1'b1;
            end else begin
              state_next = STATE_SWEEP;
              len_next   = count;
              step_next  = '0;
            end
          end
          default: begin
            if (pos_x >= cnt_x) begin
              pend_set         = 1'b1;
              pend_next.status = ST_RANGE;
            end else begin
              state_next = STATE_SWEEP;
              len_next   = count;
              step_next  = '0;
            end
          end
        endcase
      end
    end else begin
      // head word leaves cell 0; kept words rejoin behind the unprocessed ones
      ctl.cmd   = CMD_SWEEP;
      len_next  = len_after;
      step_next = step + CW'(1);
      if (read_hit) begin
        rdata_next = head;
      end
      if (last_step) begin
        state_next = STATE_IDLE;
        pend_set   = 1'b1;
        if (mode_r == MODE_DELVAL) begin
          count_next              = len_after;
          pend_next.removed_count = FILL_W'(count - len_after);
        end else begin
          pend_next.read_data = read_hit ? head : rdata_r;
        end
      end
    end
    pend_next.fill_count = FILL_W'(count_next);
  end

  assign out_load = pend_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= STATE_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (pend_set) begin
        pend_valid <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len     <= len_next;
    step    <= step_next;
    rdata_r <= rdata_next;
    if (accept) begin
      mode_r  <= req.mode;
      value_r <= req.value;
      pos_r   <= req.position;
    end
    if (pend_set) begin
      pend <= pend_next;
    end
    if (out_load) begin
      out_q <= pend;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_q.status;
  assign rsp.fill_count    = out_q.fill_count;
  assign rsp.read_data     = out_q.read_data;
  assign rsp.removed_count = out_q.removed_count;

  `SAI_ASSERT_NOW(a_count_cap, 1'b1, count <= CAP_C, "fill count above capacity")
  `SAI_ASSERT_NOW(a_len_range, state == STATE_SWEEP, len <= count && len != '0, "sweep length out of range")
  `SAI_ASSERT_NOW(a_pend_free, pend_set, !pend_valid, "staged result overwritten")
  `SAI_ASSERT_NEXT(a_ins_count, accept && req.mode == MODE_INSERT && count < CAP_C && pos_x <= cnt_x, count == $past(count) + CW'(1), "insert did not grow fill count")

endmodule

// File: sv/shift_array_insert_delete_unit.sv
// shift array insert/delete unit: ordered array of signed words in a cell chain
// insert, delete and rejected operations: staging register, then output register
// delete-by-value and read sweep the chain once, one word a cycle, before staging
// no new request is taken while a sweep runs or a result waits in the staging register;
// the single sweep passes every word through cell 0
// reset (rst, synchronous) empties the array and drops any pending output word
module shift_array_insert_delete_unit #(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  sai_req_if.sink  req,
  sai_rsp_if.source rsp
);
  import sai_pkg::*;

  logic signed [DATA_W-1:0] q [CAPACITY];
  cell_ctl_t                ctl;

  sai_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .head(q[0]),
    .ctl (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = q[i];
    end else begin : g_inner_r
      assign right = q[i+1];
    end
    sai_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left (left),
      .right(right),
      .head (q[0]),
      .q    (q[i])
    );
  end

endmodule

// File: test/tb_shift_array_insert_delete_unit.sv
// testbench for shift_array_insert_delete_unit: directed and random array operations
// checked word by word against an in-bench predictor of the shift array
// depends on sai_pkg, sai_if and the unit itself
`timescale 1ns / 100ps

module tb_shift_array_insert_delete_unit;
  import sai_pkg::*;

  localparam int CAP = 16;
  localparam int MAX_GAP = 12;
  localparam int DRAIN_CYCLES = CAP + 24;

  logic clk = 1'b0;
  logic rst;

  sai_req_if req_ch ();
  sai_rsp_if rsp_ch ();

  shift_array_insert_delete_unit #(
    .CAPACITY(CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted array contents, updated as each word is accepted
  logic signed [DATA_W-1:0] held_words [CAP];
  int                       held_count;
  result_t                  pending_results [$];

  int error_count;
  bit send_idle;
  bit recv_idle;
  int hold_cycles;

  function automatic int draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic result_t apply_array_op(logic [MODE_W-1:0] mode,
                                             logic signed [DATA_W-1:0] value,
                                             logic [POS_W-1:0] position);
    result_t res;
    int      i;
    int      kept;
    res = '0;
    case (mode)
      MODE_INSERT: begin
        if (held_count >= CAP) begin
          res.status = ST_FULL;
        end else if (int'(position) > held_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = held_count; i > int'(position); i--) held_words[i] = held_words[i-1];
          held_words[position] = value;
          held_count++;
        end
      end
      MODE_DELETE: begin
        if (int'(position) >= held_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(position); i + 1 < held_count; i++) held_words[i] = held_words[i+1];
          held_count--;
          res.removed_count = FILL_W'(1);
        end
      end
      MODE_DELVAL: begin
        kept = 0;
        for (i = 0; i < held_count; i++) begin
          if (held_words[i] != value) begin
            held_words[kept] = held_words[i];
            kept++;
          end
        end
        res.removed_count = FILL_W'(held_count - kept);
        held_count = kept;
      end
      default: begin
        if (int'(position) >= held_count) res.status = ST_RANGE;
        else res.read_data = held_words[position];
      end
    endcase
    res.fill_count = FILL_W'(held_count);
    return res;
  endfunction

  // offer one word, return at the edge that accepts it
  task automatic send_word(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value,
                           logic [POS_W-1:0] position);
    int gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= mode;
    req_ch.value    <= value;
    req_ch.position <= position;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_results.push_back(apply_array_op(mode, value, position));
  endtask

  task automatic test_directed_ops();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_word(MODE_READ, 32'sd0, 5'd0);
    send_word(MODE_DELETE, 32'sd0, 5'd0);
    send_word(MODE_DELVAL, 32'sd0, 5'd0);
    send_word(MODE_INSERT, 32'sd7, 5'd1);
    send_word(MODE_INSERT, 32'sh7fff_ffff, 5'd0);
    send_word(MODE_INSERT, 32'sh8000_0000, 5'd0);
    send_word(MODE_INSERT, -32'sd1, 5'd2);
    send_word(MODE_INSERT, 32'sd0, 5'd31);
    // adjacent duplicates plus one more at the tail
    send_word(MODE_INSERT, 32'sd5, 5'd1);
    send_word(MODE_INSERT, 32'sd5, 5'd1);
    send_word(MODE_INSERT, 32'sd5, 5'd5);
    send_word(MODE_READ, 32'sd0, 5'd5);
    send_word(MODE_READ, 32'sd0, 5'd0);
    send_word(MODE_READ, 32'sd0, 5'd6);
    send_word(MODE_READ, 32'sd0, 5'd31);
    send_word(MODE_DELVAL, 32'sd5, 5'd0);
    send_word(MODE_DELVAL, 32'sd12345, 5'd0);
    send_word(MODE_DELETE, 32'sd0, 5'd31);
    send_word(MODE_DELETE, 32'sd0, 5'd2);
    send_word(MODE_DELETE, 32'sd0, 5'd0);
    send_word(MODE_READ, 32'sd0, 5'd0);
    send_word(MODE_DELETE, 32'sd0, 5'd0);
  endtask

  task automatic test_full_array();
    logic signed [DATA_W-1:0] fill_val;
    fill_val = 32'sh0f0f_f0f0;
    while (held_count < CAP)
      send_word(MODE_INSERT, fill_val, POS_W'($urandom_range(0, held_count)));
    // fullness wins over a bad position
    send_word(MODE_INSERT, 32'sd1, 5'd0);
    send_word(MODE_INSERT, 32'sd1, 5'd31);
    send_word(MODE_READ, 32'sd0, 5'd15);
    send_word(MODE_READ, 32'sd0, 5'd16);
    send_word(MODE_DELETE, 32'sd0, 5'd16);
    send_word(MODE_DELVAL, fill_val, 5'd0);
  endtask

  task automatic random_word(int grow_pct);
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    int                       roll;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) begin
      mode = MODE_INSERT;
    end else begin
      roll = $urandom_range(0, 9);
      mode = (roll < 4) ? MODE_DELETE : (roll < 8) ? MODE_READ : MODE_DELVAL;
    end
    // small value pool makes repeated entries common
    if ($urandom_range(0, 2) == 0) value = $urandom;
    else value = DATA_W'($signed($urandom_range(0, 7)) - 4);
    if (mode == MODE_DELVAL && held_count > 0 && $urandom_range(0, 9) < 7)
      value = held_words[$urandom_range(0, held_count - 1)];
    if ($urandom_range(0, 9) == 0) position = POS_W'($urandom_range(0, 31));
    else if (mode == MODE_INSERT) position = POS_W'($urandom_range(0, held_count));
    else position = (held_count == 0) ? '0 : POS_W'($urandom_range(0, held_count - 1));
    send_word(mode, value, position);
  endtask

  task automatic test_random_ops(int n, bit s_idle, bit r_idle);
    int k;
    int grow_pct;
    send_idle = s_idle;
    recv_idle = r_idle;
    grow_pct = 50;
    for (k = 0; k < n; k++) begin
      // shift the insert bias now and then so the fill sweeps its whole range
      if (k % 60 == 0) grow_pct = $urandom_range(15, 85);
      random_word(grow_pct);
    end
  endtask

  task automatic test_backpressure();
    int k;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_cycles <= 300;
    for (k = 0; k < 50; k++) random_word(60);
  endtask

  always @(posedge clk) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  // response side: random stalls, then compare each word with the oldest prediction
  initial begin : response_check
    int      stall;
    result_t exp_res;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_gap(recv_idle);
      if (stall > 0 || hold_cycles != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_cycles != 0) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("unexpected word: status %0d fill_count %0d", rsp_ch.status, rsp_ch.fill_count);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.fill_count !== exp_res.fill_count) begin
          $error("fill_count: expected %0d, got %0d", exp_res.fill_count, rsp_ch.fill_count);
          error_count++;
        end
        if (rsp_ch.read_data !== exp_res.read_data) begin
          $error("read_data: expected %0d, got %0d", exp_res.read_data, rsp_ch.read_data);
          error_count++;
        end
        if (rsp_ch.removed_count !== exp_res.removed_count) begin
          $error("removed_count: expected %0d, got %0d", exp_res.removed_count,
                 rsp_ch.removed_count);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #1000000;
    $display("[shift_array_insert_delete_unit] ERROR");
    $finish;
  end

  initial begin : run_tests
    error_count = 0;
    held_count = 0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_cycles = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_INSERT;
    req_ch.value <= '0;
    req_ch.position <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_full_array();
    test_random_ops(400, 1'b1, 1'b1);
    test_backpressure();
    test_random_ops(200, 1'b0, 1'b0);
    test_random_ops(200, 1'b1, 1'b0);
    test_random_ops(200, 1'b0, 1'b1);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[shift_array_insert_delete_unit] OK");
    end else begin
      $display("[shift_array_insert_delete_unit] ERROR");
    end
    $finish;
  end

endmodule
